// ===== rtl/gfsp_pkg.sv =====
package gfsp_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChN      = 8'h4E;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChE      = 8'h45;
  localparam logic [7:0] ChW      = 8'h57;
  localparam logic [7:0] ChZero   = 8'h30;

  localparam logic [1:0] GNeeded     = 2'd3;
  localparam logic [2:0] HeaderLimit = 3'd5;

  localparam logic [7:0] MinSatReset = 8'd4;
  localparam logic [7:0] MaxSatReset = 8'd32;

  typedef enum logic [1:0] {
    CFG_MIN_SAT = 2'd0,
    CFG_MAX_SAT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] lat_whole;
    logic [23:0] lat_fraction;
    logic [15:0] lon_whole;
    logic [23:0] lon_fraction;
    logic [7:0]  satellites;
    logic        lat_south;
    logic        lon_east;
    logic        fix_usable;
  } fix_t;

endpackage

// ===== rtl/gfsp_parser.sv =====
module gfsp_parser import gfsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] min_sat_i,
  input  logic [7:0] max_sat_i,
  output logic       fix_valid_o,
  output fix_t       fix_o
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhHeader   = 4'd1;
  localparam logic [3:0] PhSkipId   = 4'd2;
  localparam logic [3:0] PhSkipTime = 4'd3;
  localparam logic [3:0] PhLatWhole = 4'd4;
  localparam logic [3:0] PhLatFrac  = 4'd5;
  localparam logic [3:0] PhLatMark  = 4'd6;
  localparam logic [3:0] PhLatComma = 4'd7;
  localparam logic [3:0] PhLonWhole = 4'd8;
  localparam logic [3:0] PhLonFrac  = 4'd9;
  localparam logic [3:0] PhLonMark  = 4'd10;
  localparam logic [3:0] PhLonComma = 4'd11;
  localparam logic [3:0] PhSkipFix  = 4'd12;
  localparam logic [3:0] PhSats     = 4'd13;

  // acc*10 + c - '0'; low bits of the result depend only on low bits of acc
  function automatic logic [23:0] mac10(input logic [23:0] acc, input logic [7:0] c);
    mac10 = (acc << 3) + (acc << 1) + {16'd0, c} - {16'd0, ChZero};
  endfunction

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [1:0]  gcnt_q, gcnt_d;
  logic [15:0] lat_whole_q, lat_whole_d;
  logic [23:0] lat_frac_q, lat_frac_d;
  logic [15:0] lon_whole_q, lon_whole_d;
  logic [23:0] lon_frac_q, lon_frac_d;
  logic [7:0]  sat_q, sat_d;
  logic        south_q, south_d;
  logic        east_q, east_d;
  logic [2:0]  hdr_inc;
  logic [1:0]  g_inc;
  logic        emit;

  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    gcnt_d      = gcnt_q;
    lat_whole_d = lat_whole_q;
    lat_frac_d  = lat_frac_q;
    lon_whole_d = lon_whole_q;
    lon_frac_d  = lon_frac_q;
    sat_d       = sat_q;
    south_d     = south_q;
    east_d      = east_q;
    emit        = 1'b0;
    hdr_inc     = hdr_q + 3'd1;
    g_inc       = gcnt_q + ((byte_i == ChG) ? 2'd1 : 2'd0);
    if (byte_valid_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (byte_i == ChDollar) begin
            hdr_d   = 3'd0;
            gcnt_d  = 2'd0;
            phase_d = PhHeader;
          end
        end
        PhHeader: begin
          hdr_d  = hdr_inc;
          gcnt_d = g_inc;
          if (g_inc == GNeeded) begin
            lat_whole_d = '0;
            lat_frac_d  = '0;
            lon_whole_d = '0;
            lon_frac_d  = '0;
            sat_d       = '0;
            south_d     = 1'b0;
            east_d      = 1'b0;
            phase_d     = PhSkipId;
          end else if (hdr_inc >= HeaderLimit) begin
            phase_d = PhIdle;
          end
        end
        PhSkipId, PhSkipTime, PhLatComma, PhLonComma, PhSkipFix: begin
          if (byte_i == ChComma) phase_d = phase_q + 4'd1;
        end
        PhLatWhole: begin
          if (byte_i == ChPoint) phase_d = PhLatFrac;
          else lat_whole_d = 16'(mac10({8'd0, lat_whole_q}, byte_i));
        end
        PhLatFrac: begin
          if (byte_i == ChComma) phase_d = PhLatMark;
          else lat_frac_d = mac10(lat_frac_q, byte_i);
        end
        PhLatMark: begin
          if (byte_i == ChN || byte_i == ChS) begin
            south_d = (byte_i == ChS);
            phase_d = PhLatComma;
          end
        end
        PhLonWhole: begin
          if (byte_i == ChPoint) phase_d = PhLonFrac;
          else lon_whole_d = 16'(mac10({8'd0, lon_whole_q}, byte_i));
        end
        PhLonFrac: begin
          if (byte_i == ChComma) phase_d = PhLonMark;
          else lon_frac_d = mac10(lon_frac_q, byte_i);
        end
        PhLonMark: begin
          if (byte_i == ChW || byte_i == ChE) begin
            east_d  = (byte_i == ChE);
            phase_d = PhLonComma;
          end
        end
        PhSats: begin
          if (byte_i == ChComma) begin
            emit    = 1'b1;
            phase_d = PhIdle;
          end else begin
            sat_d = 8'(mac10({16'd0, sat_q}, byte_i));
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_q       <= '0;
      gcnt_q      <= '0;
      lat_whole_q <= '0;
      lat_frac_q  <= '0;
      lon_whole_q <= '0;
      lon_frac_q  <= '0;
      sat_q       <= '0;
      south_q     <= 1'b0;
      east_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      gcnt_q      <= gcnt_d;
      lat_whole_q <= lat_whole_d;
      lat_frac_q  <= lat_frac_d;
      lon_whole_q <= lon_whole_d;
      lon_frac_q  <= lon_frac_d;
      sat_q       <= sat_d;
      south_q     <= south_d;
      east_q      <= east_d;
    end
  end

  assign fix_valid_o         = emit;
  assign fix_o.lat_whole     = lat_whole_q;
  assign fix_o.lat_fraction  = lat_frac_q;
  assign fix_o.lon_whole     = lon_whole_q;
  assign fix_o.lon_fraction  = lon_frac_q;
  assign fix_o.satellites    = sat_q;
  assign fix_o.lat_south     = south_q;
  assign fix_o.lon_east      = east_q;
  assign fix_o.fix_usable    = (min_sat_i <= sat_q) && (sat_q <= max_sat_i);

endmodule

// ===== rtl/gfsp_out_buf.sv =====
module gfsp_out_buf import gfsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  fix_t data_i,
  output logic full_o,
  output logic out_valid_o,
  output fix_t out_data_o,
  input  logic out_stall_i
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  fix_t out_q, out_d;
  fix_t skid_q, skid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      // output held by receiver: park the new item
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/gps_fix_sentence_parser.sv =====
// GGA-style fix sentence parser.
// Input channel: one ASCII byte per item on rx_byte_i, taken at a clock edge
// with in_valid_i high and in_stall_o low. A byte can be taken every cycle while in_stall_o is low.
// Output channel: one fix item per sentence, presented with out_valid_o and
// taken at an edge where out_stall_i is low. The item is registered when the
// comma that ends the satellite field is taken, into the output register or,
// if that is held, into the skid entry; the parser state updates on every byte.
// Results go into an output register backed by one skid entry; in_stall_o
// rises only when both are occupied, i.e. after the receiver has stalled
// across two finished sentences. Bytes that finish no sentence are still
// taken while a result waits, as long as the skid entry is free.
// Configuration: cfg_we_i with cfg_idx_i 0 writes the minimum satellite
// count, 1 the maximum; other indexes are ignored. Write only when idle.
// Reset (rst_ni low, asynchronous) puts the parser in the wait-for-'$'
// state, empties the output buffer and loads min 4, max 32.
module gps_fix_sentence_parser import gfsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] lat_whole_o,
  output logic [23:0] lat_fraction_o,
  output logic [15:0] lon_whole_o,
  output logic [23:0] lon_fraction_o,
  output logic [7:0]  satellites_o,
  output logic        lat_south_o,
  output logic        lon_east_o,
  output logic        fix_usable_o
);

  logic [7:0] min_sat_q;
  logic [7:0] max_sat_q;
  logic       in_take;
  logic       fix_valid;
  fix_t       fix;
  fix_t       out_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sat_q <= MinSatReset;
      max_sat_q <= MaxSatReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_SAT: min_sat_q <= cfg_data_i;
        CFG_MAX_SAT: max_sat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_take = in_valid_i && !in_stall_o;

  gfsp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_take),
    .byte_i       (rx_byte_i),
    .min_sat_i    (min_sat_q),
    .max_sat_i    (max_sat_q),
    .fix_valid_o  (fix_valid),
    .fix_o        (fix)
  );

  gfsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fix_valid),
    .data_i      (fix),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_fix),
    .out_stall_i (out_stall_i)
  );

  assign lat_whole_o    = out_fix.lat_whole;
  assign lat_fraction_o = out_fix.lat_fraction;
  assign lon_whole_o    = out_fix.lon_whole;
  assign lon_fraction_o = out_fix.lon_fraction;
  assign satellites_o   = out_fix.satellites;
  assign lat_south_o    = out_fix.lat_south;
  assign lon_east_o     = out_fix.lon_east;
  assign fix_usable_o   = out_fix.fix_usable;

`ifndef SYNTHESIS
  // the skid entry is only used behind a held output item
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry occupied with empty output register");

  // a fresh result needs a byte taken on the cycle before
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an accepted byte");

  // skid fills only from a result pushed while the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i && in_valid_i))
    else $error("skid entry filled without a stalled output");
`endif

endmodule

// ===== dv/gfsp_fix_checker.sv =====
module gfsp_fix_checker import gfsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] lat_whole_i,
  input  logic [23:0] lat_fraction_i,
  input  logic [15:0] lon_whole_i,
  input  logic [23:0] lon_fraction_i,
  input  logic [7:0]  satellites_i,
  input  logic        lat_south_i,
  input  logic        lon_east_i,
  input  logic        fix_usable_i,
  output int          mismatches_o,
  output int          fixes_pending_o,
  output int          fixes_checked_o,
  output int          usable_checked_o
);

  localparam int PrintCap = 50;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_HEADER    = 4'd1,
    PH_SKIP_ID   = 4'd2,
    PH_SKIP_TIME = 4'd3,
    PH_LAT_INT   = 4'd4,
    PH_LAT_FRAC  = 4'd5,
    PH_LAT_MARK  = 4'd6,
    PH_LAT_TAIL  = 4'd7,
    PH_LON_INT   = 4'd8,
    PH_LON_FRAC  = 4'd9,
    PH_LON_MARK  = 4'd10,
    PH_LON_TAIL  = 4'd11,
    PH_SKIP_FIX  = 4'd12,
    PH_SAT       = 4'd13
  } parse_phase_e;

  parse_phase_e parse_st;
  logic [2:0]   hdr_len;
  logic [1:0]   g_hits;
  logic [15:0]  lat_int;
  logic [23:0]  lat_frac;
  logic [15:0]  lon_int;
  logic [23:0]  lon_frac;
  logic [7:0]   sat_cnt;
  logic         is_south;
  logic         is_east;
  logic [7:0]   sat_min;
  logic [7:0]   sat_max;

  fix_t expected_fixes[$];
  fix_t seen_fix;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int usable_cnt;

  assign mismatches_o     = mismatch_cnt;
  assign fixes_pending_o  = pending_cnt;
  assign fixes_checked_o  = checked_cnt;
  assign usable_checked_o = usable_cnt;

  assign seen_fix = {lat_whole_i, lat_fraction_i, lon_whole_i, lon_fraction_i,
                     satellites_i, lat_south_i, lon_east_i, fix_usable_i};

  // value*10 + (byte - '0'); callers keep the low bits they need
  function automatic logic [23:0] digit_acc(logic [23:0] acc, logic [7:0] c);
    return acc * 24'd10 + {16'd0, c} - {16'd0, ChZero};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintCap) $display("mismatch at fix %0d: %s", checked_cnt, msg);
  endtask

  task automatic parse_byte(input logic [7:0] c);
    fix_t f;
    case (parse_st)
      PH_IDLE: begin
        if (c == ChDollar) begin
          hdr_len  = '0;
          g_hits   = '0;
          parse_st = PH_HEADER;
        end
      end
      PH_HEADER: begin
        hdr_len = hdr_len + 3'd1;
        if (c == ChG) g_hits = g_hits + 2'd1;
        if (g_hits == GNeeded) begin
          lat_int  = '0;
          lat_frac = '0;
          lon_int  = '0;
          lon_frac = '0;
          sat_cnt  = '0;
          is_south = 1'b0;
          is_east  = 1'b0;
          parse_st = PH_SKIP_ID;
        end else if (hdr_len >= HeaderLimit) begin
          parse_st = PH_IDLE;
        end
      end
      PH_SKIP_ID:   if (c == ChComma) parse_st = PH_SKIP_TIME;
      PH_SKIP_TIME: if (c == ChComma) parse_st = PH_LAT_INT;
      PH_LAT_TAIL:  if (c == ChComma) parse_st = PH_LON_INT;
      PH_LON_TAIL:  if (c == ChComma) parse_st = PH_SKIP_FIX;
      PH_SKIP_FIX:  if (c == ChComma) parse_st = PH_SAT;
      PH_LAT_INT: begin
        if (c == ChPoint) parse_st = PH_LAT_FRAC;
        else lat_int = 16'(digit_acc({8'd0, lat_int}, c));
      end
      PH_LAT_FRAC: begin
        if (c == ChComma) parse_st = PH_LAT_MARK;
        else lat_frac = digit_acc(lat_frac, c);
      end
      PH_LAT_MARK: begin
        // anything but N or S is ignored here
        if (c == ChN || c == ChS) begin
          is_south = (c == ChS);
          parse_st = PH_LAT_TAIL;
        end
      end
      PH_LON_INT: begin
        if (c == ChPoint) parse_st = PH_LON_FRAC;
        else lon_int = 16'(digit_acc({8'd0, lon_int}, c));
      end
      PH_LON_FRAC: begin
        if (c == ChComma) parse_st = PH_LON_MARK;
        else lon_frac = digit_acc(lon_frac, c);
      end
      PH_LON_MARK: begin
        if (c == ChW || c == ChE) begin
          is_east  = (c == ChE);
          parse_st = PH_LON_TAIL;
        end
      end
      PH_SAT: begin
        if (c == ChComma) begin
          f.lat_whole    = lat_int;
          f.lat_fraction = lat_frac;
          f.lon_whole    = lon_int;
          f.lon_fraction = lon_frac;
          f.satellites   = sat_cnt;
          f.lat_south    = is_south;
          f.lon_east     = is_east;
          f.fix_usable   = (sat_min <= sat_cnt) && (sat_cnt <= sat_max);
          expected_fixes.push_back(f);
          parse_st = PH_IDLE;
        end else begin
          sat_cnt = 8'(digit_acc({16'd0, sat_cnt}, c));
        end
      end
      default: parse_st = PH_IDLE;
    endcase
  endtask

  task automatic check_fix(input fix_t got);
    fix_t want;
    if (expected_fixes.size() == 0) begin
      report_mismatch($sformatf("fix with none expected, satellites %0d", got.satellites));
    end else begin
      want = expected_fixes.pop_front();
      if (got.lat_whole != want.lat_whole)
        report_mismatch($sformatf("lat_whole %0d, expected %0d", got.lat_whole,
                                  want.lat_whole));
      if (got.lat_fraction != want.lat_fraction)
        report_mismatch($sformatf("lat_fraction %0d, expected %0d", got.lat_fraction,
                                  want.lat_fraction));
      if (got.lon_whole != want.lon_whole)
        report_mismatch($sformatf("lon_whole %0d, expected %0d", got.lon_whole,
                                  want.lon_whole));
      if (got.lon_fraction != want.lon_fraction)
        report_mismatch($sformatf("lon_fraction %0d, expected %0d", got.lon_fraction,
                                  want.lon_fraction));
      if (got.satellites != want.satellites)
        report_mismatch($sformatf("satellites %0d, expected %0d", got.satellites,
                                  want.satellites));
      if (got.lat_south != want.lat_south)
        report_mismatch($sformatf("lat_south %0b, expected %0b", got.lat_south,
                                  want.lat_south));
      if (got.lon_east != want.lon_east)
        report_mismatch($sformatf("lon_east %0b, expected %0b", got.lon_east,
                                  want.lon_east));
      if (got.fix_usable !== want.fix_usable)
        report_mismatch($sformatf("fix_usable %0b, expected %0b (satellites %0d)",
                                  got.fix_usable, want.fix_usable, want.satellites));
      checked_cnt++;
      if (want.fix_usable) usable_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_st = PH_IDLE;
      hdr_len  = '0;
      g_hits   = '0;
      lat_int  = '0;
      lat_frac = '0;
      lon_int  = '0;
      lon_frac = '0;
      sat_cnt  = '0;
      is_south = 1'b0;
      is_east  = 1'b0;
      sat_min  = MinSatReset;
      sat_max  = MaxSatReset;
      expected_fixes.delete();
      mismatch_cnt = 0;
      pending_cnt  = 0;
      checked_cnt  = 0;
      usable_cnt   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_fix(seen_fix);
      if (in_valid_i && !in_stall_i) parse_byte(rx_byte_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_SAT) sat_min = cfg_data_i;
        else if (cfg_idx_i == CFG_MAX_SAT) sat_max = cfg_data_i;
      end
      pending_cnt = expected_fixes.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import gfsp_pkg::*;

  localparam int         HoldCycles = 400;
  localparam int         NumPhases  = 6;
  localparam logic [1:0] SpareIdxLo = 2'd2;
  localparam logic [1:0] SpareIdxHi = 2'd3;
  localparam logic [7:0] ChUpperA   = 8'h41;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] lat_whole;
  logic [23:0] lat_fraction;
  logic [15:0] lon_whole;
  logic [23:0] lon_fraction;
  logic [7:0]  satellites;
  logic        lat_south;
  logic        lon_east;
  logic        fix_usable;

  int mismatches;
  int fixes_pending;
  int fixes_checked;
  int usable_checked;

  bit idling_on = 1'b1;
  bit hold_req  = 1'b0;

  int         sentence_bytes;
  int         noise_bytes;
  int         settings_run;
  logic [7:0] cur_min = MinSatReset;
  logic [7:0] cur_max = MaxSatReset;
  logic [7:0] line_q[$];

  gps_fix_sentence_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .lat_whole_o    (lat_whole),
    .lat_fraction_o (lat_fraction),
    .lon_whole_o    (lon_whole),
    .lon_fraction_o (lon_fraction),
    .satellites_o   (satellites),
    .lat_south_o    (lat_south),
    .lon_east_o     (lon_east),
    .fix_usable_o   (fix_usable)
  );

  gfsp_fix_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .lat_whole_i      (lat_whole),
    .lat_fraction_i   (lat_fraction),
    .lon_whole_i      (lon_whole),
    .lon_fraction_i   (lon_fraction),
    .satellites_i     (satellites),
    .lat_south_i      (lat_south),
    .lon_east_i       (lon_east),
    .fix_usable_i     (fix_usable),
    .mismatches_o     (mismatches),
    .fixes_pending_o  (fixes_pending),
    .fixes_checked_o  (fixes_checked),
    .usable_checked_o (usable_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic drive_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi);
    write_reg(CFG_MIN_SAT, lo);
    write_reg(CFG_MAX_SAT, hi);
    if ($urandom_range(0, 1) == 0) write_reg(SpareIdxHi, 8'($urandom_range(0, 255)));
    cur_min = lo;
    cur_max = hi;
    settings_run++;
  endtask

  // wait for every expected fix, then idle so the parser is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (fixes_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) drive_byte(line_q[i]);
    sentence_bytes += line_q.size();
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_line();
  endtask

  function automatic logic [7:0] rand_letter();
    return ChUpperA + 8'($urandom_range(0, 25));
  endfunction

  // mostly digits, now and then a stray byte that is neither point nor comma
  task automatic push_digits(input int n);
    logic [7:0] ch;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        ch = 8'($urandom_range(0, 255));
        if (ch == ChPoint || ch == ChComma) ch = ChZero;
      end else begin
        ch = ChZero + 8'($urandom_range(0, 9));
      end
      line_q.push_back(ch);
    end
  endtask

  task automatic push_mark(input logic [7:0] a, input logic [7:0] b);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_q.push_back(rand_letter());
    line_q.push_back($urandom_range(0, 1) ? a : b);
    line_q.push_back(ChComma);
  endtask

  task automatic send_random_sentence(input bit broken);
    int kind;
    int v;
    int cut;
    line_q.push_back(ChDollar);
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      line_q.push_back(ChG);
      line_q.push_back(rand_letter());
      line_q.push_back(ChG);
      line_q.push_back(ChG);
      line_q.push_back(rand_letter());
    end else if (kind <= 8) begin
      repeat (5) line_q.push_back(($urandom_range(0, 9) < 6) ? ChG : rand_letter());
    end else begin
      repeat (5) line_q.push_back(8'($urandom_range(0, 255)));
    end
    line_q.push_back(ChComma);
    push_digits($urandom_range(0, 8));
    line_q.push_back(ChComma);
    push_digits($urandom_range(0, 7));
    line_q.push_back(ChPoint);
    push_digits($urandom_range(0, 9));
    line_q.push_back(ChComma);
    push_mark(ChN, ChS);
    push_digits($urandom_range(0, 7));
    line_q.push_back(ChPoint);
    push_digits($urandom_range(0, 9));
    line_q.push_back(ChComma);
    push_mark(ChE, ChW);
    push_digits(1);
    line_q.push_back(ChComma);
    // satellite count, weighted toward the current limits
    case ($urandom_range(0, 9))
      0, 1:    v = int'(cur_min) + $urandom_range(0, 2) - 1;
      2, 3:    v = int'(cur_max) + $urandom_range(0, 2) - 1;
      4:       v = $urandom_range(0, 999);
      default: v = $urandom_range(0, 40);
    endcase
    if (v < 0) v = 0;
    if ($urandom_range(0, 19) != 0) begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(ChZero);
      push_text($sformatf("%0d", v));
    end
    line_q.push_back(ChComma);
    push_text("M,\r\n");
    if (broken) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
    send_line();
  endtask

  initial begin
    int start_bytes;
    int start_fixes;
    int r;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_MIN_SAT;
    cfg_data       = 8'd0;
    in_valid       = 1'b0;
    rx_byte        = 8'd0;
    sentence_bytes = 0;
    noise_bytes    = 0;
    settings_run   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // writes to unused indexes must leave the reset limits alone
    write_reg(SpareIdxLo, 8'hFF);
    write_reg(SpareIdxHi, 8'h00);

    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,M,545.4,M,,*47\r\n");
    send_text("$GNGGA,000000,0000.0,S,00000.0,W,0,00,\r\n");
    send_text("$GGGGG,235959,65535.16777215,S,65535.16777215,E,2,255,\r\n");
    send_text("$GPGGA,1,65536.16777216,N,99999.99999999,W,1,256,\r\n");
    send_text("$GPRMC,1,2.3,N,4.5,E,1,7,\r\n");
    send_text("$PGQGG,1,12.5,S,3.4,E,1,9,\r\n");
    // comma inside the whole-degree field, empty latitude fraction and longitude whole part
    send_text("$GPGGA,1,,12.,N,.5,E,1,5,\r\n");
    send_text("$GPGGA,1,4A07.0x38,N,01Z31.0 0,E,1,1#,\r\n");
    send_text("$GPGGA,1$2,$12.3,N,4.5,E,1,6,\r\n");
    send_text("$GPGGA,1,48.1,XQN,11.2,NSE,1,4,\r\n");
    send_text("$GPGGA,1,1.1,N,1.1,W,1,3,\r\n");
    send_text("$GPGGA,1,1.1,N,1.1,E,1,32,\r\n");
    send_text("$GPGGA,1,1.1,S,1.1,W,1,33,\r\n");
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       set_limits(8'd0, 8'd255);
        1:       set_limits(8'd255, 8'd0);
        2:       set_limits(8'd0, 8'd0);
        3:       set_limits(8'd255, 8'd255);
        4:       set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: set_limits(MinSatReset, MaxSatReset);
      endcase
      if (p == 0) hold_req = 1'b1;
      if (p == NumPhases - 1) idling_on = 1'b0;
      start_bytes = sentence_bytes;
      start_fixes = fixes_checked + fixes_pending;
      while (sentence_bytes - start_bytes < 150 ||
             fixes_checked + fixes_pending - start_fixes < 3) begin
        r = $urandom_range(0, 19);
        if (r < 16) begin
          send_random_sentence(1'b0);
        end else if (r < 18) begin
          send_random_sentence(1'b1);
        end else begin
          repeat ($urandom_range(3, 20)) begin
            drive_byte(8'($urandom_range(0, 255)));
            noise_bytes++;
          end
        end
      end
      settle();
    end

    for (int i = 0; i < 10000 && fixes_pending != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("covered %0d sentence bytes and %0d noise bytes across %0d limit settings",
             sentence_bytes, noise_bytes, settings_run + 1);
    $display("%0d fixes compared (%0d usable), %0d mismatches, %0d fixes never seen",
             fixes_checked, usable_checked, mismatches, fixes_pending);
    if (mismatches == 0 && fixes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
